// ===== src/lss_pkg.sv =====
// shared types and codes for the lifo stack with search
package lss_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNDER = 2'd1;
  localparam logic [1:0] STAT_OVER  = 2'd2;

  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_LOAD,
    S_SRCH_CMP
  } state_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic empty;
    logic full;
    logic multi;
    logic hit;
    logic last;
  } stat_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic busy;
    logic push_ok;
    logic push_over;
    logic pop_ok;
    logic pop_under;
    logic pop_fetch;
    logic srch_start;
    logic srch_empty;
    logic srch_step;
    logic srch_done;
    logic clr;
    logic load_top;
  } ctrl_t;

endpackage

// ===== src/lifo_stack_with_search_top.sv =====
// lifo stack of signed words with a membership search, top level and datapath
//
// a transaction is taken at a rising edge where start is high and busy is low;
// in_operation selects push, pop, search or clear and in_value carries the word.
// every transaction gives exactly one result, shown on the out_ ports for one
// cycle with out_valid high; the receiver has no way to hold it off.
// push, clear, a refused push, pop on one or no entries and search on empty: the result
// shows in the cycle after the accepting edge and busy stays low.
// pop with two or more entries: result in the next cycle, busy for one cycle
// while the new top word is read back from the store.
// search: one comparator scans the store from the bottom, one word a cycle
// through the registered ram read port, and stops at the first match or at the
// top entry, with busy high while it compares.
// the stored words hold top of stack in a register, so push and pop touch the
// ram through one write or one read.
// reset empties the stack at once; the ram contents are never cleared since
// only occupied entries are ever read.
module lifo_stack_with_search_top #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic               out_found,
  output logic               out_is_empty,
  output logic               out_is_full,
  output logic [1:0]         out_status
);

  import lss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  stat_t stat;
  ctrl_t ctrl;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [WORD_W-1:0] top_r;
  logic [WORD_W-1:0] val_r;
  logic [AW-1:0]     idx_r;
  logic [AW-1:0]     idx_nxt;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  logic              out_valid_r;
  logic [WORD_W-1:0] res_r;
  logic              found_r;
  logic              empty_r;
  logic              full_r;
  logic [1:0]        status_r;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.multi = (count_r >= CW'(2));
  assign stat.hit   = (rd_data == val_r);
  assign stat.last  = ({{(CW-AW){1'b0}}, idx_r} == (count_r - CW'(1)));

  lss_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_operation),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // read port: new top after pop, first word of a scan, or the next scan word
  always_comb begin
    rd_en   = ctrl.pop_fetch || ctrl.srch_start || ctrl.srch_step;
    rd_addr = '0;
    if (ctrl.pop_fetch) begin
      rd_addr = AW'(count_r - CW'(2));
    end else if (ctrl.srch_step) begin
      rd_addr = idx_r + AW'(1);
    end
  end

  lss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctrl.push_ok),
    .wr_addr (AW'(count_r)),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clr) begin
      count_nxt = '0;
    end else if (ctrl.push_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.pop_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (ctrl.srch_start) begin
      idx_nxt = '0;
    end else if (ctrl.srch_step) begin
      idx_nxt = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= ctrl.push_ok || ctrl.push_over || ctrl.pop_ok || ctrl.pop_under ||
                     ctrl.srch_empty || ctrl.srch_done || ctrl.clr;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctrl.srch_start) begin
      val_r <= in_value;
    end
    if (ctrl.push_ok) begin
      top_r <= in_value;
    end else if (ctrl.load_top) begin
      top_r <= rd_data;
    end
  end

  // result registers, loaded in the cycle a transaction finishes
  always_ff @(posedge clk) begin
    if (ctrl.push_ok) begin
      res_r    <= in_value;
      found_r  <= 1'b0;
      empty_r  <= 1'b0;
      full_r   <= (count_nxt == CW'(DEPTH));
      status_r <= STAT_OK;
    end else if (ctrl.push_over) begin
      res_r    <= top_r;
      found_r  <= 1'b0;
      empty_r  <= 1'b0;
      full_r   <= 1'b1;
      status_r <= STAT_OVER;
    end else if (ctrl.pop_ok) begin
      res_r    <= top_r;
      found_r  <= 1'b0;
      empty_r  <= (count_nxt == '0);
      full_r   <= 1'b0;
      status_r <= STAT_OK;
    end else if (ctrl.pop_under || ctrl.srch_empty || ctrl.clr) begin
      res_r    <= '0;
      found_r  <= 1'b0;
      empty_r  <= 1'b1;
      full_r   <= 1'b0;
      status_r <= ctrl.pop_under ? STAT_UNDER : STAT_OK;
    end else if (ctrl.srch_done) begin
      res_r    <= top_r;
      found_r  <= stat.hit;
      empty_r  <= 1'b0;
      full_r   <= stat.full;
      status_r <= STAT_OK;
    end
  end

  assign busy             = ctrl.busy;
  assign out_valid        = out_valid_r;
  assign out_result_value = res_r;
  assign out_found        = found_r;
  assign out_is_empty     = empty_r;
  assign out_is_full      = full_r;
  assign out_status       = status_r;

endmodule

// ===== src/lss_ram.sv =====
// generic single write port ram with registered read
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/lss_fsm.sv =====
// sequencer for push, pop refill and the one-word-a-cycle search scan
module lss_fsm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    operation,
  input  lss_pkg::stat_t stat,
  output lss_pkg::ctrl_t ctrl
);

  import lss_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;
  logic   scan_end;

  assign accept   = start && (state_r == S_IDLE);
  assign scan_end = stat.hit || stat.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (operation == OP_POP && stat.multi) begin
            state_nxt = S_POP_LOAD;
          end else if (operation == OP_SEARCH && !stat.empty) begin
            state_nxt = S_SRCH_CMP;
          end
        end
      end
      S_POP_LOAD: begin
        state_nxt = S_IDLE;
      end
      S_SRCH_CMP: begin
        if (scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (operation)
            OP_PUSH: begin
              ctrl.push_ok   = !stat.full;
              ctrl.push_over = stat.full;
            end
            OP_POP: begin
              ctrl.pop_ok    = !stat.empty;
              ctrl.pop_under = stat.empty;
              ctrl.pop_fetch = stat.multi;
            end
            OP_SEARCH: begin
              ctrl.srch_start = !stat.empty;
              ctrl.srch_empty = stat.empty;
            end
            OP_CLEAR: begin
              ctrl.clr = 1'b1;
            end
            default: begin
              ctrl.clr = 1'b1;
            end
          endcase
        end
      end
      S_POP_LOAD: begin
        ctrl.load_top = 1'b1;
      end
      S_SRCH_CMP: begin
        ctrl.srch_done = scan_end;
        ctrl.srch_step = !scan_end;
      end
      default: begin
        ctrl.busy = 1'b1;
      end
    endcase
  end

endmodule
